FILE: hdl/assert_macros.svh
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/md5_pkg.sv
// Types, constants and round functions of the MD5 digest block
`timescale 1ns / 1ps
package md5_pkg;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LEN_POS = 56;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        BE_IDLE, BE_PAD, BE_ROUND, BE_FOLD, BE_OUT0, BE_OUT1
    } be_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction
endpackage

FILE: hdl/md5_front.sv
// Input stage: registers items into a two-entry queue toward the core
`timescale 1ns / 1ps
module md5_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  md5_pkg::item_t s_item,
    output logic          q_valid,
    input  logic          q_ready,
    output md5_pkg::item_t q_item
);
    md5_pkg::item_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    // items with no byte and no last flag change nothing: drop them here
    assign s_ready  = (cnt_reg != 2'd2);
    assign push     = s_valid && s_ready && (s_item.valid || s_item.last);
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
        if (push) mem_reg[wp_reg] <= s_item;
    end
endmodule

FILE: hdl/md5_core.sv
// Compression core: block buffer, padding sequencer, round unit and output
`timescale 1ns / 1ps
module md5_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  md5_pkg::item_t q_item,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [63:0]   m_digest_half,
    output logic          m_half_index,
    output logic          m_final_half
);
    md5_pkg::be_state_t state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [60:0] total_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pad_pos_reg;
    logic        last_reg;   // compression belongs to the final block
    logic        extra_reg;  // a length-only block still follows
    logic [5:0]  pos;
    logic [3:0]  widx;
    logic [31:0] f, sum, rot, nb;
    logic        take;
    logic [63:0] bits;

    assign pos  = total_reg[5:0];
    assign bits = {total_reg, 3'b000};
    assign q_ready = (state_reg == md5_pkg::BE_IDLE);
    assign take = q_valid && q_ready;

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin f = (b_reg & c_reg) | (~b_reg & d_reg); widx = rnd_reg[3:0]; end
            2'd1: begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                widx = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2: begin f = b_reg ^ c_reg ^ d_reg; widx = 4'(3 * rnd_reg[3:0] + 5); end
            default: begin f = c_reg ^ (b_reg | ~d_reg); widx = 4'(7 * rnd_reg[3:0]); end
        endcase
        sum = a_reg + f + blk_reg[widx] + md5_pkg::round_k(rnd_reg);
        rot = (sum << md5_pkg::round_s(rnd_reg))
            | (sum >> (6'd32 - {1'b0, md5_pkg::round_s(rnd_reg)}));
        nb  = b_reg + rot;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::BE_IDLE: if (take) begin
                if (q_item.valid && pos == 6'd63) state_next = md5_pkg::BE_ROUND;
                else if (q_item.last) state_next = md5_pkg::BE_PAD;
            end
            md5_pkg::BE_PAD: if (pad_pos_reg == 6'd63) state_next = md5_pkg::BE_ROUND;
            md5_pkg::BE_ROUND: if (rnd_reg == 6'd63) state_next = md5_pkg::BE_FOLD;
            md5_pkg::BE_FOLD: begin
                if (extra_reg) state_next = md5_pkg::BE_ROUND;
                else if (last_reg) state_next = md5_pkg::BE_OUT0;
                else state_next = md5_pkg::BE_IDLE;
            end
            md5_pkg::BE_OUT0: if (m_ready) state_next = md5_pkg::BE_OUT1;
            md5_pkg::BE_OUT1: if (m_ready) state_next = md5_pkg::BE_IDLE;
            default: state_next = md5_pkg::BE_IDLE;
        endcase
    end

    always_comb begin
        m_valid = (state_reg == md5_pkg::BE_OUT0) || (state_reg == md5_pkg::BE_OUT1);
        m_half_index = (state_reg == md5_pkg::BE_OUT1);
        m_final_half = m_half_index;
        m_digest_half = m_half_index ? {cv_reg[3], cv_reg[2]} : {cv_reg[1], cv_reg[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= md5_pkg::BE_IDLE;
            cv_reg[0] <= md5_pkg::IV0; cv_reg[1] <= md5_pkg::IV1;
            cv_reg[2] <= md5_pkg::IV2; cv_reg[3] <= md5_pkg::IV3;
            total_reg <= '0;
            rnd_reg <= '0;
            last_reg <= 1'b0;
            extra_reg <= 1'b0;
            pad_pos_reg <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                md5_pkg::BE_IDLE: if (take) begin
                    if (q_item.valid) begin
                        blk_reg[pos[5:2]][8*pos[1:0] +: 8] <= q_item.data;
                        total_reg <= total_reg + 61'd1;
                    end
                    // pad position starts after the byte just taken
                    pad_pos_reg <= pos + {5'd0, q_item.valid};
                    last_reg <= q_item.last;
                    // full block with last flag: pad block starts at zero afterwards
                    extra_reg <= q_item.valid && pos == 6'd63 && q_item.last;
                    a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
                    c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
                end
                md5_pkg::BE_PAD: begin
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                    if (pad_pos_reg == 6'd63 && pos < 6'(md5_pkg::LEN_POS)) begin
                        blk_reg[14] <= bits[31:0];
                        blk_reg[15] <= bits[63:32];
                    end else begin
                        blk_reg[pad_pos_reg[5:2]][8*pad_pos_reg[1:0] +: 8] <=
                            (pad_pos_reg == pos) ? md5_pkg::PAD_BYTE : 8'h00;
                    end
                    if (pad_pos_reg == 6'd63 && pos >= 6'(md5_pkg::LEN_POS))
                        extra_reg <= 1'b1;
                end
                md5_pkg::BE_ROUND: begin
                    a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= nb;
                    rnd_reg <= rnd_reg + 6'd1;
                end
                md5_pkg::BE_FOLD: begin
                    cv_reg[0] <= cv_reg[0] + a_reg; cv_reg[1] <= cv_reg[1] + b_reg;
                    cv_reg[2] <= cv_reg[2] + c_reg; cv_reg[3] <= cv_reg[3] + d_reg;
                    a_reg <= cv_reg[0] + a_reg; b_reg <= cv_reg[1] + b_reg;
                    c_reg <= cv_reg[2] + c_reg; d_reg <= cv_reg[3] + d_reg;
                    if (extra_reg) begin
                        extra_reg <= 1'b0;
                        for (int i = 1; i < 14; i++) blk_reg[i] <= '0;
                        // pad byte lands at word 0 when the message filled the block
                        blk_reg[0] <= (pos == 6'd0) ? {24'd0, md5_pkg::PAD_BYTE} : 32'd0;
                        blk_reg[14] <= bits[31:0];
                        blk_reg[15] <= bits[63:32];
                    end
                end
                md5_pkg::BE_OUT1: if (m_ready) begin
                    cv_reg[0] <= md5_pkg::IV0; cv_reg[1] <= md5_pkg::IV1;
                    cv_reg[2] <= md5_pkg::IV2; cv_reg[3] <= md5_pkg::IV3;
                    total_reg <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: hdl/md5_message_digest.sv
// Top level of the streaming MD5 digest block
`timescale 1ns / 1ps
// Usage:
//  Input channel s_: one message byte per transaction (s_msg_byte) with
//  s_byte_valid marking a real byte and s_is_last closing the message.
//  An item with neither flag is dropped.
//  Output channel m_: two transactions per message, digest bytes 0..7 then
//  8..15, little-endian in m_digest_half, m_final_half on the second.
//  Flow: a byte that does not fill a block passes the input queue into the
//  core, and such bytes can follow one per cycle while the core is idle. A
//  64th byte starts the 64 rounds and the fold on the single round unit.
//  The last item adds padding up to the end of the block and one or two
//  compressions before the first half shows.
//  A two-entry input queue takes up to two items while the core works.
//  Reset (aresetn low, synchronous) loads the initial chaining value and
//  clears the byte count; the core likewise returns to that state after
//  each digest. When the receiver stalls the core holds the digest half.
module md5_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_byte_valid,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_half,
    output logic        m_half_index,
    output logic        m_final_half
);
    md5_pkg::item_t s_item, q_item;
    logic q_valid, q_ready;

    assign s_item = '{data: s_msg_byte, valid: s_byte_valid, last: s_is_last};

    md5_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    md5_core u_core (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_valid(m_valid), .m_ready(m_ready),
        .m_digest_half(m_digest_half), .m_half_index(m_half_index),
        .m_final_half(m_final_half)
    );
endmodule

FILE: hdl/md5_checker.sv
// Port-level checker for the MD5 digest block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module md5_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_digest_half,
    input logic        m_half_index,
    input logic        m_final_half
);
    `ASSERT_IMPL(a_final_is_second, aclk, aresetn, m_valid, m_final_half == m_half_index)
    `ASSERT_NEXT(a_first_then_second, aclk, aresetn, m_valid && m_ready && !m_half_index, m_valid && m_half_index)
    `ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_digest_half))
endmodule

bind md5_message_digest md5_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_digest_half(m_digest_half), .m_half_index(m_half_index),
    .m_final_half(m_final_half)
);

FILE: dv/md5_message_digest_test.sv
// Self-checking testbench of the streaming MD5 digest block
`timescale 1ns / 1ps
module md5_message_digest_test;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_msg_byte;
    logic        s_byte_valid;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_digest_half;
    logic        m_half_index;
    logic        m_final_half;

    typedef struct packed {
        logic [63:0] half;
        logic        idx;
        logic        fin;
    } digest_res_t;

    md5_pkg::item_t byte_queue[$];
    digest_res_t    digest_queue[$];

    logic [31:0] chain[4];
    logic [31:0] words[16];
    logic [60:0] total;

    int  errors = 0;
    int  messages = 0;
    int  halves_seen = 0;
    bit  quiet = 0;
    bit  hold_rx = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_count = 0;
    bit  hold_fired = 0;

    md5_message_digest DUT (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    function automatic logic [31:0] add_const(int i);
        return 32'(longint'($floor(4294967296.0 * (($sin(real'(i + 1)) < 0.0) ?
            -$sin(real'(i + 1)) : $sin(real'(i + 1))))));
    endfunction

    task automatic compress();
        logic [31:0] a, b, c, d, f, sum;
        int rots[16];
        int g, j, st;
        rots = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            st = i / 16; j = i % 16;
            case (st)
                0: begin f = (b & c) | (~b & d); g = j; end
                1: begin f = (b & d) | (c & ~d); g = (5 * j + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * j + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * j) % 16; end
            endcase
            sum = a + f + words[g] + add_const(i);
            sum = b + rotl(sum, rots[st * 4 + j % 4]);
            a = d; d = c; c = b; b = sum;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic set_byte(int pos, logic [7:0] v);
        words[pos / 4][8 * (pos % 4) +: 8] = v;
    endtask

    task automatic clear_digest();
        chain = '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
        total = '0;
        foreach (words[i]) words[i] = '0;
    endtask

    // advance the digest state by one accepted transaction
    task automatic predict_digest(md5_pkg::item_t it);
        int pos;
        logic [63:0] bits;
        if (it.valid) begin
            pos = int'(total[5:0]);
            set_byte(pos, it.data);
            total = total + 1;
            if (pos == 63) compress();
        end
        if (!it.last) return;
        pos = int'(total[5:0]);
        set_byte(pos, md5_pkg::PAD_BYTE);
        for (int p = pos + 1; p < 64; p++) set_byte(p, 8'h00);
        if (pos >= md5_pkg::LEN_POS) begin
            compress();
            foreach (words[i]) words[i] = '0;
        end
        bits = {total, 3'b000};
        words[14] = bits[31:0];
        words[15] = bits[63:32];
        compress();
        digest_queue.push_back('{{chain[1], chain[0]}, 1'b0, 1'b0});
        digest_queue.push_back('{{chain[3], chain[2]}, 1'b1, 1'b1});
        messages++;
        clear_digest();
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic push_msg(int len, int mode, bit tail_byte);
        md5_pkg::item_t it;
        for (int i = 0; i < len; i++) begin
            it.data = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
            it.valid = 1'b1;
            it.last = tail_byte && (i == len - 1);
            byte_queue.push_back(it);
            if ($urandom_range(0, 19) == 0) byte_queue.push_back('{8'($urandom), 1'b0, 1'b0});
        end
        if (!tail_byte || len == 0) byte_queue.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap > 0 || byte_queue.size() == 0) begin
                s_valid <= 1'b0;
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                s_valid <= 1'b0;
                tx_gap <= $urandom_range(0, 8);
            end else begin
                s_valid <= 1'b1;
                {s_msg_byte, s_byte_valid, s_is_last} <= byte_queue.pop_front();
            end
        end
    end

    // predict at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_digest('{s_msg_byte, s_byte_valid, s_is_last});
    end

    // count the cycles of the long receiver hold
    always @(posedge aclk) begin
        if (aresetn && hold_rx && !hold_fired) begin
            hold_count <= hold_count + 1;
            if (hold_count >= 3000) hold_fired <= 1'b1;
        end
    end

    // receiver stall control and monitor
    always @(posedge aclk) begin
        digest_res_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                halves_seen++;
                if (digest_queue.size() == 0) begin
                    report("unexpected digest half", m_digest_half, 0);
                end else begin
                    w = digest_queue.pop_front();
                    if (m_digest_half !== w.half) report("digest_half", m_digest_half, w.half);
                    if (m_half_index !== w.idx) report("half_index", m_half_index, w.idx);
                    if (m_final_half !== w.fin) report("final_half", m_final_half, w.fin);
                end
            end
            if (hold_rx && !hold_fired) begin
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                rx_gap <= $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int waited;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_msg_byte = '0;
        s_byte_valid = 1'b0;
        s_is_last = 1'b0;
        m_ready = 1'b0;
        clear_digest();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, short messages, length boundaries
        byte_queue.push_back('{8'h5A, 1'b0, 1'b0});
        push_msg(0, 2, 1'b0);
        push_msg(1, 0, 1'b1);
        push_msg(1, 1, 1'b0);
        push_msg(3, 2, 1'b1);
        push_msg(55, 1, 1'b1);
        push_msg(56, 0, 1'b1);
        push_msg(63, 2, 1'b0);
        push_msg(64, 1, 1'b1);
        push_msg(65, 2, 1'b1);
        wait (byte_queue.size() == 0 && digest_queue.size() == 0);

        // long receiver hold so the input queue fills
        hold_rx = 1'b1;
        push_msg(120, 2, 1'b1);
        push_msg(10, 2, 1'b1);
        wait (hold_fired && byte_queue.size() == 0 && digest_queue.size() == 0);
        hold_rx = 1'b0;

        // sender pause until all results are back
        push_msg(20, 2, 1'b0);
        wait (byte_queue.size() == 0 && digest_queue.size() == 0);

        // random messages, mostly short
        for (int n = 0; n < 55; n++) begin
            if (n == 47) begin
                wait (byte_queue.size() == 0);
                quiet = 1'b1;
            end
            case ($urandom_range(0, 5))
                0: push_msg($urandom_range(50, 70), 2, $urandom_range(0, 1));
                1: push_msg($urandom_range(0, 4), 2, $urandom_range(0, 1));
                default: push_msg($urandom_range(0, 40), 2, $urandom_range(0, 1));
            endcase
        end
        wait (byte_queue.size() == 0 && digest_queue.size() == 0);
        waited = 0;
        while (waited < 400) begin
            @(posedge aclk);
            waited++;
        end
        $display("covered %0d messages, %0d digest halves, empty and boundary lengths",
                 messages, halves_seen);
        if (errors == 0 && digest_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
